// ----- sv/ulc_pkg.sv -----
// Shared types and constants for the UTF-8 to 8-bit character decoder.
// Used by the front, the request queue, the back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ulc_pkg;

    localparam logic [7:0] CH_QMARK = 8'd63;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam int CODE_W = 21;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } out_item_t;

    // One queue entry: the results caused by one input request (1 or 2)
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage : ulc_pkg

`default_nettype wire

// ----- sv/utf8_to_latin1_crlf_decoder.sv -----
// Top level of the UTF-8 to 8-bit character decoder with CR LF folding.
// Instantiates ulc_front, ulc_queue and ulc_back; types from ulc_pkg.
//
// Usage:
//  - Input channel in_valid / in_stall / in_item carries one request per
//    byte (action = 0) or an end-of-stream flush (action = 1). A request is
//    taken on a rising edge with in_valid high and in_stall low.
//  - Output channel out_valid / out_stall / out_item carries decoded
//    characters; last marks the final character caused by one request.
//    Requests that cause nothing (lead bytes, a held CR) emit nothing.
//  - Throughput: one input request per cycle while in_stall is low, one
//    output character per cycle while out_stall is low. The back end's single
//    output register is the limit: a request that yields two characters (held
//    CR followed by a non-LF byte) sends them in turn; the queue absorbs this.
//  - Path: the request's results are written into a queue entry on the edge
//    that takes the request, and the first character then goes into the
//    output register, when the queue was empty and the output free.
//  - in_stall rises only when the request queue (QUEUE_DEPTH entries) is
//    full, i.e. when the receiver stalls or double results pile up.
//    A stalled output holds its character; the front keeps decoding until
//    the queue fills.
//  - Reset (rst_n low, asynchronous) clears the decode state, empties the
//    queue and drops any pending output.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_latin1_crlf_decoder
    import ulc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_item
);

    q_push_t   q_push;
    q_status_t q_status;
    q_entry_t  q_head;
    logic      q_pop;

    // decode and classify
    ulc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_status (q_status),
        .q_push   (q_push)
    );

    // decouples front from output back-pressure
    ulc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (q_pop),
        .q_status (q_status),
        .head     (q_head)
    );

    // serialise one or two characters per entry
    ulc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule : utf8_to_latin1_crlf_decoder

`default_nettype wire

// ----- sv/ulc_front.sv -----
// Front end: accepts input requests, runs the UTF-8 / CR folding state
// and classifies each request into 0, 1 or 2 result characters. Uses ulc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ulc_front
    import ulc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    input  wire q_status_t q_status,
    output q_push_t        q_push
);

    logic              held_cr_reg,    held_cr_next;
    logic [1:0]        cont_left_reg,  cont_left_next;
    logic              forced_inv_reg, forced_inv_next;
    logic [CODE_W-1:0] code_bits_reg,  code_bits_next;

    logic              accept;
    logic [CODE_W-1:0] code_new;
    logic [7:0]        b;
    q_entry_t          ent;

    function automatic q_entry_t put_char(q_entry_t e, logic [7:0] ch);
        q_entry_t r;
        r = e;
        if (e.count == 2'd0)
        begin
            r.first = ch;
        end
        else
        begin
            r.second = ch;
        end
        r.count = e.count + 2'd1;
        return r;
    endfunction

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign b        = in_item.byte_value;
    assign code_new = {code_bits_reg[CODE_W-7:0], b[5:0]};

    always_comb
    begin
        ent             = '0;
        held_cr_next    = held_cr_reg;
        cont_left_next  = cont_left_reg;
        forced_inv_next = forced_inv_reg;
        code_bits_next  = code_bits_reg;

        if (in_item.action == ACT_FLUSH)
        begin
            if (cont_left_reg != 2'd0)
            begin
                ent = put_char(ent, CH_QMARK);
            end
            else if (held_cr_reg)
            begin
                ent = put_char(ent, CH_CR);
            end
            held_cr_next    = 1'b0;
            cont_left_next  = 2'd0;
            forced_inv_next = 1'b0;
            code_bits_next  = '0;
        end
        else if (held_cr_reg && b == CH_LF)
        begin
            // CR LF folds to a single LF
            held_cr_next = 1'b0;
            ent          = put_char(ent, CH_LF);
        end
        else
        begin
            if (held_cr_reg)
            begin
                held_cr_next = 1'b0;
                ent          = put_char(ent, CH_CR);
            end
            if (cont_left_reg == 2'd0)
            begin
                if (!b[7])
                begin
                    if (b == CH_CR)
                    begin
                        held_cr_next = 1'b1;
                    end
                    else
                    begin
                        ent = put_char(ent, b);
                    end
                end
                else if (!b[6])
                begin
                    ent = put_char(ent, CH_QMARK);
                end
                else if (!b[5])
                begin
                    cont_left_next  = 2'd1;
                    forced_inv_next = 1'b0;
                    code_bits_next  = {{(CODE_W-5){1'b0}}, b[4:0]};
                end
                else if (!b[4])
                begin
                    cont_left_next  = 2'd2;
                    forced_inv_next = 1'b0;
                    code_bits_next  = {{(CODE_W-4){1'b0}}, b[3:0]};
                end
                else if (!b[3])
                begin
                    cont_left_next  = 2'd3;
                    forced_inv_next = 1'b0;
                    code_bits_next  = {{(CODE_W-3){1'b0}}, b[2:0]};
                end
                else
                begin
                    cont_left_next  = 2'd2;
                    forced_inv_next = 1'b1;
                    code_bits_next  = '0;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                // bad continuation: consumed, sequence ends
                ent             = put_char(ent, CH_QMARK);
                cont_left_next  = 2'd0;
                forced_inv_next = 1'b0;
                code_bits_next  = '0;
            end
            else if (cont_left_reg == 2'd1)
            begin
                if (forced_inv_reg || (|code_new[CODE_W-1:8]))
                begin
                    ent = put_char(ent, CH_QMARK);
                end
                else if (code_new[7:0] == CH_CR)
                begin
                    held_cr_next = 1'b1;
                end
                else
                begin
                    ent = put_char(ent, code_new[7:0]);
                end
                cont_left_next  = 2'd0;
                forced_inv_next = 1'b0;
                code_bits_next  = '0;
            end
            else
            begin
                cont_left_next = cont_left_reg - 2'd1;
                code_bits_next = code_new;
            end
        end

        q_push.valid = accept && (ent.count != 2'd0);
        q_push.entry = ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cr_reg    <= 1'b0;
            cont_left_reg  <= 2'd0;
            forced_inv_reg <= 1'b0;
            code_bits_reg  <= '0;
        end
        else if (accept)
        begin
            held_cr_reg    <= held_cr_next;
            cont_left_reg  <= cont_left_next;
            forced_inv_reg <= forced_inv_next;
            code_bits_reg  <= code_bits_next;
        end
    end

endmodule : ulc_front

`default_nettype wire

// ----- sv/ulc_queue.sv -----
// Short FIFO of result entries between front and back.
// Uses q_entry_t and the status/push structs from ulc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ulc_queue
    import ulc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_push_t q_push,
    input  wire logic    pop,
    output q_status_t    q_status,
    output q_entry_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic             do_push, do_pop;

    assign q_status.full  = (fill_reg == FULL_CNT);
    assign q_status.empty = (fill_reg == '0);
    assign do_push        = q_push.valid && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule : ulc_queue

`default_nettype wire

// ----- sv/ulc_back.sv -----
// Back end: drains queue entries and sends one result character per
// cycle while out_stall is low, through a registered output. Uses ulc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ulc_back
    import ulc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_status,
    input  wire q_entry_t  head,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg,       out_next;
    logic      pending_reg,   pending_next;
    logic [7:0] second_reg,   second_next;
    logic      out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pending_next   = pending_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (out_free)
        begin
            if (pending_reg)
            begin
                out_valid_next    = 1'b1;
                out_next.char_out = second_reg;
                out_next.last     = 1'b1;
                pending_next      = 1'b0;
            end
            else if (!q_status.empty)
            begin
                pop               = 1'b1;
                out_valid_next    = 1'b1;
                out_next.char_out = head.first;
                out_next.last     = (head.count == 2'd1);
                pending_next      = (head.count == 2'd2);
                second_next       = head.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        second_reg <= second_next;
    end

endmodule : ulc_back

`default_nettype wire
